// ----- hw/rtl/rgb_to_nv12_converter_assert.svh -----
// ----------------------------------------------------------------------------
// RGB to NV12 converter assertion macros
// Shared property wrappers for the converter's port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_NV12_CONVERTER_ASSERT_SVH
`define RGB_TO_NV12_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RGBNV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RGBNV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rgbnv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbnv_pkg
// Types, coefficients and codes shared by the RGB to NV12 converter.
// ----------------------------------------------------------------------------
package rgbnv_pkg;

  localparam int CFG_DW = 13;
  localparam int CFG_IW = 2;
  localparam int OFF_W  = 24;

  localparam logic [CFG_IW-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IDX_MIRROR = 2'd2;

  localparam logic [CFG_DW-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DW-1:0] HEIGHT_RST = 13'd480;

  // Luma, Q16
  localparam logic [23:0] Y_R = 24'd19595;
  localparam logic [23:0] Y_G = 24'd38470;
  localparam logic [23:0] Y_B = 24'd7471;

  // Chroma on four-pixel sums, Q18
  localparam logic signed [27:0] U_R  = -28'sd11076;
  localparam logic signed [27:0] U_G  = -28'sd21692;
  localparam logic signed [27:0] U_B  = 28'sd32768;
  localparam logic signed [27:0] V_R  = 28'sd32768;
  localparam logic signed [27:0] V_G  = -28'sd27460;
  localparam logic signed [27:0] V_B  = -28'sd5308;
  localparam logic signed [27:0] C_BIAS = 28'sd33554432;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // Column pair sums, one line store entry
  typedef struct packed {
    logic [8:0] b;
    logic [8:0] g;
    logic [8:0] r;
  } psum_t;

  typedef struct packed {
    logic chroma;  // item closes a 2x2 block and emits U and V
    logic dbl;     // final even row paired with itself
    logic fend;    // last pixel of the frame
  } flags_t;

  typedef struct packed {
    logic [OFF_W-1:0] luma_off;
    logic [OFF_W-1:0] chroma_off;
    logic [7:0]       y;
    logic [7:0]       u;
    logic [7:0]       v;
    flags_t           flags;
  } res_t;

  typedef enum logic [1:0] {
    SLOT_LUMA,
    SLOT_U,
    SLOT_V
  } slot_t;

  // Floor a signed Q18 value to a byte, clamp to 0..255
  function automatic logic [7:0] q18_to_byte(input logic signed [27:0] v);
    logic [7:0] res;
    if (v[27]) begin
      res = 8'd0;
    end else if (v[26]) begin
      res = 8'd255;
    end else begin
      res = v[25:18];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/rgbnv_line_mem.sv -----
// ----------------------------------------------------------------------------
// rgbnv_line_mem
// Line store of even-row column pair sums, single port, registered read.
// ----------------------------------------------------------------------------
module rgbnv_line_mem
  import rgbnv_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  psum_t         wdata,
  output psum_t         rdata_r
);

  psum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

// ----- hw/rtl/rgbnv_front.sv -----
// ----------------------------------------------------------------------------
// rgbnv_front
// Raster position tracking, even-column hold, pair sums and line store access.
// ----------------------------------------------------------------------------
module rgbnv_front
  import rgbnv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int WW    = $clog2(MAX_WIDTH + 1),
  localparam int HW    = $clog2(MAX_HEIGHT + 1),
  localparam int DEPTH = MAX_WIDTH / 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [WW-1:0] w_eff,
  input  logic [HW-1:0] h_eff,
  input  logic          in_valid,
  output logic          in_stall,
  input  pix_t          in_pix,
  input  logic          s1_take,
  output logic          s1_valid_r,
  output logic [CW-1:0] s1_col_r,
  output logic [RW-1:0] s1_row_r,
  output pix_t          s1_pix_r,
  output psum_t         s1_sum_r,
  output flags_t        s1_flags_r,
  output logic          mem_we,
  output logic          mem_re,
  output logic [AW-1:0] mem_addr,
  output psum_t         mem_wdata
);

  localparam int HX = HW + 1;

  logic [CW-1:0] col_r, col_nxt, cur_col, idx_full;
  logic [RW-1:0] row_r, row_nxt, cur_row;
  logic [HX-1:0] row_pre;
  pix_t          held_r;
  logic          accept, wrap, last_col, last_row, odd, even_row;
  psum_t         sum;
  flags_t        flags;

  assign in_stall = s1_valid_r && !s1_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // Normalize a stale position left by a smaller frame
    wrap    = WW'(col_r) >= w_eff;
    cur_col = wrap ? '0 : col_r;
    row_pre = wrap ? HX'(row_r) + HX'(1) : HX'(row_r);
    if (row_pre >= HX'(h_eff)) begin
      row_pre = '0;
    end
    cur_row  = row_pre[RW-1:0];
    last_col = WW'(cur_col) == (w_eff - WW'(1));
    last_row = HW'(cur_row) == (h_eff - HW'(1));
    odd      = cur_col[0];
    even_row = !cur_row[0];

    col_nxt = last_col ? '0 : cur_col + CW'(1);
    row_nxt = cur_row;
    if (last_col) begin
      row_nxt = last_row ? '0 : cur_row + RW'(1);
    end

    sum.r = 9'(held_r.red)   + 9'(in_pix.red);
    sum.g = 9'(held_r.green) + 9'(in_pix.green);
    sum.b = 9'(held_r.blue)  + 9'(in_pix.blue);

    flags.chroma = odd && (!even_row || last_row);
    flags.dbl    = odd && even_row && last_row;
    flags.fend   = last_row && last_col;

    idx_full  = cur_col >> 1;
    mem_addr  = idx_full[AW-1:0];
    mem_wdata = sum;
    // Writes land on even rows, reads on odd rows, so an entry is never
    // read and written at the same edge.
    mem_we    = accept && odd && even_row;
    mem_re    = accept && odd && !even_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        s1_valid_r <= 1'b1;
        if (!odd) begin
          held_r <= in_pix;
        end
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= cur_col;
      s1_row_r   <= cur_row;
      s1_pix_r   <= in_pix;
      s1_sum_r   <= sum;
      s1_flags_r <= flags;
    end
  end

endmodule

// ----- hw/rtl/rgbnv_calc.sv -----
// ----------------------------------------------------------------------------
// rgbnv_calc
// Offsets, luma and chroma sums in one stage, chroma bytes in the next.
// ----------------------------------------------------------------------------
module rgbnv_calc
  import rgbnv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int PW = RW + WW + 1,
  localparam int OW = (PW > OFF_W) ? PW : OFF_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [WW-1:0] w_eff,
  input  logic          mirror,
  input  logic          s1_valid,
  input  logic [CW-1:0] s1_col,
  input  logic [RW-1:0] s1_row,
  input  pix_t          s1_pix,
  input  psum_t         s1_sum,
  input  flags_t        s1_flags,
  input  psum_t         mem_rdata,
  output logic          s1_take,
  input  logic          s3_take,
  output logic          s3_valid_r,
  output res_t          s3_r
);

  logic             s2_valid_r, s2_ready, s3_ready;
  logic [OFF_W-1:0] s2_luma_off_r, s2_chroma_off_r;
  logic [7:0]       s2_y_r;
  logic [9:0]       s2_sr_r, s2_sg_r, s2_sb_r;
  flags_t           s2_flags_r;

  logic [WW-1:0]    mir_col, xo, xc;
  logic [OW-1:0]    luma_full, chroma_full;
  logic [23:0]      y_acc;
  logic [9:0]       sr, sg, sb;
  logic signed [27:0] sr_s, sg_s, sb_s, u_acc, v_acc;
  res_t             s3_nxt;

  assign s3_ready = !s3_valid_r || s3_take;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_take  = s1_valid && s2_ready;

  // Offsets, luma and four-pixel sums
  always_comb begin
    mir_col     = w_eff - WW'(1) - WW'(s1_col);
    xo          = mirror ? mir_col : WW'(s1_col);
    xc          = mirror ? mir_col : WW'(s1_col) - WW'(1);
    luma_full   = OW'(s1_row) * OW'(w_eff) + OW'(xo);
    chroma_full = OW'(s1_row >> 1) * OW'(w_eff) + OW'(xc);
    y_acc       = 24'(s1_pix.red) * Y_R + 24'(s1_pix.green) * Y_G
                + 24'(s1_pix.blue) * Y_B;
    if (s1_flags.dbl) begin
      sr = {s1_sum.r, 1'b0};
      sg = {s1_sum.g, 1'b0};
      sb = {s1_sum.b, 1'b0};
    end else begin
      sr = 10'(s1_sum.r) + 10'(mem_rdata.r);
      sg = 10'(s1_sum.g) + 10'(mem_rdata.g);
      sb = 10'(s1_sum.b) + 10'(mem_rdata.b);
    end
  end

  // Chroma bytes
  always_comb begin
    sr_s  = $signed({18'd0, s2_sr_r});
    sg_s  = $signed({18'd0, s2_sg_r});
    sb_s  = $signed({18'd0, s2_sb_r});
    u_acc = U_R * sr_s + U_G * sg_s + U_B * sb_s + C_BIAS;
    v_acc = V_R * sr_s + V_G * sg_s + V_B * sb_s + C_BIAS;
    s3_nxt.luma_off   = s2_luma_off_r;
    s3_nxt.chroma_off = s2_chroma_off_r;
    s3_nxt.y          = s2_y_r;
    s3_nxt.u          = q18_to_byte(u_acc);
    s3_nxt.v          = q18_to_byte(v_acc);
    s3_nxt.flags      = s2_flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_luma_off_r   <= luma_full[OFF_W-1:0];
      s2_chroma_off_r <= chroma_full[OFF_W-1:0];
      s2_y_r          <= y_acc[23:16];
      s2_sr_r         <= sr;
      s2_sg_r         <= sg;
      s2_sb_r         <= sb;
      s2_flags_r      <= s1_flags;
    end
    if (s3_ready && s2_valid_r) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// ----- hw/rtl/rgbnv_emit.sv -----
// ----------------------------------------------------------------------------
// rgbnv_emit
// Sends the luma, U and V transactions of one finished pixel in order.
// ----------------------------------------------------------------------------
module rgbnv_emit
  import rgbnv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s3_valid,
  input  res_t             s3,
  output logic             s3_take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_plane,
  output logic [OFF_W-1:0] out_byte_offset,
  output logic [7:0]       out_sample_value,
  output logic             out_last_of_run,
  output logic             out_frame_end
);

  slot_t slot_r, slot_nxt;
  logic  last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_LUMA;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  always_comb begin
    last      = !s3.flags.chroma || (slot_r == SLOT_V);
    out_valid = s3_valid;
    out_plane = slot_r != SLOT_LUMA;
    slot_nxt  = slot_r;
    case (slot_r)
      SLOT_U: begin
        out_byte_offset  = s3.chroma_off;
        out_sample_value = s3.u;
        if (s3_valid && !out_stall) slot_nxt = SLOT_V;
      end
      SLOT_V: begin
        out_byte_offset  = s3.chroma_off + OFF_W'(1);
        out_sample_value = s3.v;
        if (s3_valid && !out_stall) slot_nxt = SLOT_LUMA;
      end
      default: begin
        out_byte_offset  = s3.luma_off;
        out_sample_value = s3.y;
        if (s3_valid && !out_stall && !last) slot_nxt = SLOT_U;
      end
    endcase
    out_last_of_run = last;
    out_frame_end   = last && s3.flags.fend;
    s3_take         = s3_valid && !out_stall && last;
  end

endmodule

// ----- hw/rtl/rgb_to_nv12_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_nv12_converter
// Streaming RGB to NV12 (BT.601 full range, 4:2:0) converter, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one RGB pixel per input transaction in raster order (in_valid,
//   in_stall). Every pixel yields a luma transaction on the result channel
//   with its byte offset in the luma plane (mirrored when mirror_r is
//   set). The odd column of an odd row, or of a final even row, also yields
//   a U then a V transaction at the interleaved chroma plane offset.
//   last_of_run marks the final transaction of a pixel, frame_end the final
//   transaction of the frame.
//   Pipeline: a pixel passes three pipeline registers (front end, calc
//   stage two, calc stage three) before its first result shows.
//   Throughput: one pixel per cycle while out_stall is low; a pixel that
//   closes a 2x2 block sends Y, U and V on the single result port and holds
//   the input meanwhile, so an odd row (or a final even row) sends eight
//   results per four pixels, an even row four. The result port sets the rate.
//   Reset: position returns to frame start, registers to 640x480 without
//   mirroring. The line store is not cleared; each odd row reads only
//   entries that the even row above it wrote.
//   Stall: out_stall freezes the result; the three stages keep filling and
//   in_stall rises once all are occupied. Write registers only while idle.
// ----------------------------------------------------------------------------
module rgb_to_nv12_converter
  import rgbnv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_plane,
  output logic [OFF_W-1:0]  out_byte_offset,
  output logic [7:0]        out_sample_value,
  output logic              out_last_of_run,
  output logic              out_frame_end
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [13:0] W_CAP = 14'((MAX_WIDTH / 2) * 2);
  localparam logic [13:0] H_CAP = 14'(MAX_HEIGHT);

  // Configuration registers
  logic [CFG_DW-1:0] frame_width_r, frame_height_r;
  logic              mirror_r;

  logic [13:0]   w14, h14;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  pix_t          in_pix;

  // Stage 1 transaction from the front end
  logic          s1_valid, s1_take;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  pix_t          s1_pix;
  psum_t         s1_sum;
  flags_t        s1_flags;

  // Line store port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  psum_t         mem_wdata, mem_rdata;

  // Finished pixel
  logic          s3_valid, s3_take;
  res_t          s3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      mirror_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  frame_width_r  <= cfg_data;
        CFG_IDX_HEIGHT: frame_height_r <= cfg_data;
        CFG_IDX_MIRROR: mirror_r       <= cfg_data[0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Effective frame size: width forced even, both clamped to legal range
  always_comb begin
    w14 = {1'b0, frame_width_r[CFG_DW-1:1], 1'b0};
    if (w14 < 14'd2) begin
      w14 = 14'd2;
    end else if (w14 > W_CAP) begin
      w14 = W_CAP;
    end
    h14 = {1'b0, frame_height_r};
    if (h14 == 14'd0) begin
      h14 = 14'd1;
    end else if (h14 > H_CAP) begin
      h14 = H_CAP;
    end
    w_eff = w14[WW-1:0];
    h_eff = h14[HW-1:0];
  end

  assign in_pix = '{blue: in_blue, green: in_green, red: in_red};

  rgbnv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pix     (in_pix),
    .s1_take    (s1_take),
    .s1_valid_r (s1_valid),
    .s1_col_r   (s1_col),
    .s1_row_r   (s1_row),
    .s1_pix_r   (s1_pix),
    .s1_sum_r   (s1_sum),
    .s1_flags_r (s1_flags),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata)
  );

  rgbnv_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata)
  );

  rgbnv_calc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .w_eff      (w_eff),
    .mirror     (mirror_r),
    .s1_valid   (s1_valid),
    .s1_col     (s1_col),
    .s1_row     (s1_row),
    .s1_pix     (s1_pix),
    .s1_sum     (s1_sum),
    .s1_flags   (s1_flags),
    .mem_rdata  (mem_rdata),
    .s1_take    (s1_take),
    .s3_take    (s3_take),
    .s3_valid_r (s3_valid),
    .s3_r       (s3)
  );

  rgbnv_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .s3_valid         (s3_valid),
    .s3               (s3),
    .s3_take          (s3_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plane        (out_plane),
    .out_byte_offset  (out_byte_offset),
    .out_sample_value (out_sample_value),
    .out_last_of_run  (out_last_of_run),
    .out_frame_end    (out_frame_end)
  );

endmodule

// ----- hw/rtl/rgbnv_port_chk.sv -----
// ----------------------------------------------------------------------------
// rgbnv_port_chk
// Port-level checks on the converter's result channel.
// ----------------------------------------------------------------------------
`include "rgb_to_nv12_converter_assert.svh"

module rgbnv_port_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_plane,
  input logic [23:0] out_byte_offset,
  input logic [7:0]  out_sample_value,
  input logic        out_last_of_run,
  input logic        out_frame_end
);

  // A stalled result holds its payload
  `RGBNV_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(out_plane) && $stable(out_byte_offset) && $stable(out_sample_value), "stalled result changed")

  // A transaction that is not the last of its pixel is followed at once by chroma
  `RGBNV_ASSERT_NEXT(a_chroma_follows, out_valid && !out_stall && !out_last_of_run, out_valid && out_plane, "chroma transaction missing after non-final result")

  // V lands one byte after U
  `RGBNV_ASSERT_NEXT(a_v_after_u, out_valid && !out_stall && out_plane && !out_last_of_run, out_byte_offset == $past(out_byte_offset) + 24'd1, "V offset does not follow U")

  // Frame end only on the final transaction of a pixel
  `RGBNV_ASSERT_NOW(a_fend_last, out_valid && out_frame_end, out_last_of_run, "frame end without last of run")

endmodule

bind rgb_to_nv12_converter rgbnv_port_chk u_port_chk (.*);
